// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the level match gain RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/alm_pkg.sv -----
// Package for the level match gain block: payload types, widths and register codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int ENERGY_WIDTH = 48;
   localparam int COEF_WIDTH   = 32;
   localparam int GAIN_WIDTH   = 32;
   localparam int GAIN_OUT_WIDTH = 31;
   localparam int BOOT_WIDTH   = 17;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 48;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENERGY_COEF    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVITY_COEF  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_UP_COEF   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_DOWN_COEF = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOOT_COEF      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOOT_LENGTH    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GATE_ENERGY    = 3'd6;

   localparam logic [COEF_WIDTH-1:0]   RST_ENERGY_COEF    = 32'd4294862000;
   localparam logic [COEF_WIDTH-1:0]   RST_ACTIVITY_COEF  = 32'd4293849000;
   localparam logic [COEF_WIDTH-1:0]   RST_GAIN_UP_COEF   = 32'd4294868000;
   localparam logic [COEF_WIDTH-1:0]   RST_GAIN_DOWN_COEF = 32'd4294768000;
   localparam logic [COEF_WIDTH-1:0]   RST_BOOT_COEF      = 32'd4294154000;
   localparam logic [BOOT_WIDTH-1:0]   RST_BOOT_LENGTH    = 17'd16800;
   localparam logic [ENERGY_WIDTH-1:0] RST_GATE_ENERGY    = 48'd22250000;

   localparam logic [GAIN_WIDTH-1:0] UNITY_GAIN = 32'd1073741824;

   // Serial multiplier: signed multiplicand, unsigned multiplier.
   localparam int MUL_M_WIDTH = 50;
   localparam int MUL_N_WIDTH = 32;
   localparam int PROD_WIDTH  = MUL_M_WIDTH + 1 + MUL_N_WIDTH;

   // Ratio numerator and denominator are energies plus one LSB.
   localparam int RATIO_WIDTH = ENERGY_WIDTH + 1;
   localparam int ROOT_WIDTH  = 31;
   localparam int QUO_WIDTH   = 2 * ROOT_WIDTH;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] ref_left;
      logic signed [SAMPLE_WIDTH-1:0] ref_right;
      logic signed [SAMPLE_WIDTH-1:0] proc_left;
      logic signed [SAMPLE_WIDTH-1:0] proc_right;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] out_left;
      logic signed [SAMPLE_WIDTH-1:0] out_right;
      logic [GAIN_OUT_WIDTH-1:0]      gain_now;
   } rsp_type;

   typedef struct packed {
      logic                          start;
      logic signed [MUL_M_WIDTH-1:0] mcand;
      logic [MUL_N_WIDTH-1:0]        mplier;
   } mul_req_type;

   typedef struct packed {
      logic                   start;
      logic [RATIO_WIDTH-1:0] num;
      logic [RATIO_WIDTH-1:0] den;
   } ds_req_type;

endpackage

`default_nettype wire

// ----- hdl/alm_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on alm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alm_mul import alm_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire mul_req_type                  mul_req,
   output logic                              done,
   output logic signed [PROD_WIDTH-1:0]      product
);

   localparam int CNT_WIDTH = $clog2(MUL_N_WIDTH);

   logic signed [MUL_M_WIDTH:0]   hi_ff, hi_in;
   logic [MUL_N_WIDTH-1:0]        lo_ff, lo_in;
   logic signed [MUL_M_WIDTH-1:0] mcand_ff, mcand_in;
   logic [CNT_WIDTH-1:0]          count_ff, count_in;
   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic signed [MUL_M_WIDTH+1:0] sum;

   always_comb begin
      sum = (MUL_M_WIDTH+2)'(hi_ff) +
            (lo_ff[0] ? (MUL_M_WIDTH+2)'(mcand_ff) : '0);
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (run_ff) begin
         // Add, then shift the partial product right by one bit.
         hi_in    = sum[MUL_M_WIDTH+1:1];
         lo_in    = {sum[0], lo_ff[MUL_N_WIDTH-1:1]};
         count_in = count_ff + CNT_WIDTH'(1);
         if (count_ff == CNT_WIDTH'(MUL_N_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (mul_req.start) begin
         hi_in    = '0;
         lo_in    = mul_req.mplier;
         mcand_in = mul_req.mcand;
         count_in = '0;
         run_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
      count_ff <= count_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

   `ALM_ASSERT_IMPLIES(a_mul_no_restart, clock, reset, mul_req.start, !run_ff,
      "multiply started while one is running")

endmodule

`default_nettype wire

// ----- hdl/alm_divsqrt.sv -----
// Serial restoring divider followed by a digit-by-digit square root.
// Gives floor(sqrt(num * 2^60 / den)); one quotient bit or one root bit per cycle.
// Depends on alm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module alm_divsqrt import alm_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ds_req_type             ds_req,
   output logic                        done,
   output logic [ROOT_WIDTH-1:0]       root
);

   localparam int DIV_WIDTH = RATIO_WIDTH + 2;
   localparam int REM_WIDTH = ROOT_WIDTH + 3;
   localparam int CNT_WIDTH = $clog2(QUO_WIDTH);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_SQRT = 2'd2;

   logic [1:0]            phase_ff, phase_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic [DIV_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [QUO_WIDTH-1:0]  quo_ff, quo_in;
   logic [REM_WIDTH-1:0]  sq_rem_ff, sq_rem_in;
   logic [ROOT_WIDTH-1:0] root_ff, root_in;
   logic                  done_ff, done_in;

   logic [DIV_WIDTH:0]    shifted, div_diff;
   logic                  div_ge;
   logic [REM_WIDTH+1:0]  sq_cat, trial, sq_diff;
   logic                  sq_ge;

   always_comb begin
      shifted  = {rem_ff, 1'b0};
      div_ge   = shifted >= {1'b0, dvs_ff};
      div_diff = shifted - {1'b0, dvs_ff};
      sq_cat   = {sq_rem_ff, quo_ff[QUO_WIDTH-1 -: 2]};
      trial    = (REM_WIDTH+2)'({root_ff, 2'b01});
      sq_ge    = sq_cat >= trial;
      sq_diff  = sq_cat - trial;

      phase_in  = phase_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      sq_rem_in = sq_rem_ff;
      root_in   = root_ff;
      done_in   = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (ds_req.start) begin
               // The numerator is below four times the denominator, so dividing
               // by 4*den gives all quotient bits as fraction bits.
               rem_in   = DIV_WIDTH'(ds_req.num);
               dvs_in   = {ds_req.den, 2'b00};
               quo_in   = '0;
               count_in = '0;
               phase_in = PH_DIV;
            end
         end
         PH_DIV: begin
            rem_in   = div_ge ? div_diff[DIV_WIDTH-1:0] : shifted[DIV_WIDTH-1:0];
            quo_in   = {quo_ff[QUO_WIDTH-2:0], div_ge};
            count_in = count_ff + CNT_WIDTH'(1);
            if (count_ff == CNT_WIDTH'(QUO_WIDTH - 1)) begin
               count_in  = '0;
               sq_rem_in = '0;
               root_in   = '0;
               phase_in  = PH_SQRT;
            end
         end
         PH_SQRT: begin
            sq_rem_in = sq_ge ? sq_diff[REM_WIDTH-1:0] : sq_cat[REM_WIDTH-1:0];
            root_in   = {root_ff[ROOT_WIDTH-2:0], sq_ge};
            quo_in    = {quo_ff[QUO_WIDTH-3:0], 2'b00};
            count_in  = count_ff + CNT_WIDTH'(1);
            if (count_ff == CNT_WIDTH'(ROOT_WIDTH - 1)) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      count_ff  <= count_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      sq_rem_ff <= sq_rem_in;
      root_ff   <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

   `ALM_ASSERT_IMPLIES(a_ds_done_idle, clock, reset, done_ff, phase_ff == PH_IDLE,
      "root reported while the unit is still busy")

endmodule

`default_nettype wire

// ----- hdl/auto_level_match_gain_core.sv -----
// Automatic level match gain: one result per request, the processed stereo pair scaled
// by a gain that tracks sqrt(reference energy / processed energy). Ten products pass one
// at a time through a bit-serial multiplier; when the gate is open and the ratio does
// not clamp, the ratio also goes through a serial divider of 62 steps and a root of 31
// steps. A finished result waits in an output register, so a new request is taken while
// it is still pending. Configuration writes take effect at once.
// Depends on alm_pkg, alm_mul, alm_divsqrt and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module auto_level_match_gain_core import alm_pkg::*; #(
   parameter int unsigned MIN_GAIN = 760151010,
   parameter int unsigned MAX_GAIN = 1516700552
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire req_type                     req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output rsp_type                          rsp_data,
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam logic [GAIN_WIDTH-1:0] MIN_G = GAIN_WIDTH'(MIN_GAIN);
   localparam logic [GAIN_WIDTH-1:0] MAX_G = GAIN_WIDTH'(MAX_GAIN);

   // Squares carry 2*(SAMPLE_WIDTH-1) fraction bits; energies carry 46.
   localparam int FRAC = 2 * (SAMPLE_WIDTH - 1);
   localparam int ESHR = (FRAC >= 46) ? FRAC - 46 : 0;
   localparam int ESHL = (FRAC < 46) ? 46 - FRAC : 0;
   localparam int SQ_WIDTH = 2 * MUL_N_WIDTH + 1;
   localparam int Y_WIDTH = PROD_WIDTH - 30;
   localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ISSUE = 4'd1;
   localparam logic [3:0] S_WAIT  = 4'd2;
   localparam logic [3:0] S_GATE  = 4'd3;
   localparam logic [3:0] S_ROOT  = 4'd4;
   localparam logic [3:0] S_COEF  = 4'd5;
   localparam logic [3:0] S_OUT   = 4'd6;

   localparam logic [3:0] OP_SQ_RL    = 4'd0;
   localparam logic [3:0] OP_SQ_RR    = 4'd1;
   localparam logic [3:0] OP_SQ_PL    = 4'd2;
   localparam logic [3:0] OP_SQ_PR    = 4'd3;
   localparam logic [3:0] OP_BL_REF   = 4'd4;
   localparam logic [3:0] OP_BL_PROC  = 4'd5;
   localparam logic [3:0] OP_BL_ACT   = 4'd6;
   localparam logic [3:0] OP_BL_GAIN  = 4'd7;
   localparam logic [3:0] OP_SC_LEFT  = 4'd8;
   localparam logic [3:0] OP_SC_RIGHT = 4'd9;

   function automatic logic [SAMPLE_WIDTH-1:0] mag(input logic signed [SAMPLE_WIDTH-1:0] s);
      mag = s[SAMPLE_WIDTH-1] ? (~s + SAMPLE_WIDTH'(1)) : s;
   endfunction

   function automatic logic [ENERGY_WIDTH-1:0] energy_of(input logic [SQ_WIDTH-1:0] s);
      logic [SQ_WIDTH-1:0] h;
      h = s >> 1;
      energy_of = ENERGY_WIDTH'((h >> ESHR) << ESHL);
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] saturate(input logic signed [Y_WIDTH-1:0] y);
      if (longint'(y) > SAT_HI) begin
         saturate = SAMPLE_WIDTH'(SAT_HI);
      end else if (longint'(y) < SAT_LO) begin
         saturate = SAMPLE_WIDTH'(SAT_LO);
      end else begin
         saturate = y[SAMPLE_WIDTH-1:0];
      end
   endfunction

   // Configuration registers.
   logic [COEF_WIDTH-1:0]   energy_coef_ff, energy_coef_in;
   logic [COEF_WIDTH-1:0]   activity_coef_ff, activity_coef_in;
   logic [COEF_WIDTH-1:0]   gain_up_coef_ff, gain_up_coef_in;
   logic [COEF_WIDTH-1:0]   gain_down_coef_ff, gain_down_coef_in;
   logic [COEF_WIDTH-1:0]   boot_coef_ff, boot_coef_in;
   logic [BOOT_WIDTH-1:0]   boot_length_ff, boot_length_in;
   logic [ENERGY_WIDTH-1:0] gate_energy_ff, gate_energy_in;

   // Filter state.
   logic [ENERGY_WIDTH-1:0] ref_energy_ff, ref_energy_in;
   logic [ENERGY_WIDTH-1:0] proc_energy_ff, proc_energy_in;
   logic [ENERGY_WIDTH-1:0] act_ff, act_in;
   logic [GAIN_WIDTH-1:0]   gain_ff, gain_in;
   logic [BOOT_WIDTH-1:0]   boot_left_ff, boot_left_in;

   // Per-request working registers.
   logic [3:0]              state_ff, state_in;
   logic [3:0]              op_ff, op_in;
   req_type                 req_ff, req_in;
   logic [SQ_WIDTH-1:0]     sq_ff, sq_in;
   logic [ENERGY_WIDTH-1:0] ref_inst_ff, ref_inst_in;
   logic [ENERGY_WIDTH-1:0] proc_inst_ff, proc_inst_in;
   logic                    active_ff, active_in;
   logic [GAIN_WIDTH-1:0]   target_ff, target_in;
   logic [COEF_WIDTH-1:0]   coef_ff, coef_in;
   logic [SAMPLE_WIDTH-1:0] out_left_ff, out_left_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   mul_req_type                   mul_req;
   logic                          mul_done;
   logic signed [PROD_WIDTH-1:0]  mul_product;
   ds_req_type                    ds_req;
   logic                          ds_done;
   logic [ROOT_WIDTH-1:0]         ds_root;

   logic [ENERGY_WIDTH:0]         bl_diff;
   logic [ENERGY_WIDTH-1:0]       bl_base;
   logic signed [ENERGY_WIDTH+2:0] bl_sum;
   logic [ENERGY_WIDTH-1:0]       bl_val;
   logic [SQ_WIDTH-1:0]           sq_now;
   logic [PROD_WIDTH-1:0]         scaled;
   logic [GAIN_WIDTH-1:0]         snapped;
   logic [GAIN_WIDTH-1:0]         root_ext;
   logic [RATIO_WIDTH-1:0]        num, den;

   alm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   alm_divsqrt u_divsqrt (
      .clock  (clock),
      .reset  (reset),
      .ds_req (ds_req),
      .done   (ds_done),
      .root   (ds_root)
   );

   always_comb begin
      // Blend y = b + floor(c * (a - b) / 2^32), a the held value, b the new one.
      case (op_ff)
         OP_BL_REF: begin
            bl_base = ref_inst_ff;
            bl_diff = {1'b0, ref_energy_ff} - {1'b0, ref_inst_ff};
         end
         OP_BL_PROC: begin
            bl_base = proc_inst_ff;
            bl_diff = {1'b0, proc_energy_ff} - {1'b0, proc_inst_ff};
         end
         OP_BL_ACT: begin
            bl_base = '0;
            bl_diff = {1'b0, act_ff};
         end
         default: begin
            bl_base = ENERGY_WIDTH'(target_ff);
            bl_diff = (ENERGY_WIDTH+1)'(signed'({1'b0, gain_ff} - {1'b0, target_ff}));
         end
      endcase
      bl_sum  = signed'((ENERGY_WIDTH+3)'(bl_base)) +
                (ENERGY_WIDTH+3)'(signed'(mul_product[PROD_WIDTH-1:32]));
      bl_val  = bl_sum[ENERGY_WIDTH-1:0];
      sq_now  = SQ_WIDTH'(mul_product[2*MUL_N_WIDTH-1:0]);
      scaled  = mul_product + PROD_WIDTH'(64'd536870912);
      snapped = (bl_val[GAIN_WIDTH-1:0] >= UNITY_GAIN - GAIN_WIDTH'(1) &&
                 bl_val[GAIN_WIDTH-1:0] <= UNITY_GAIN + GAIN_WIDTH'(1)) ?
                UNITY_GAIN : bl_val[GAIN_WIDTH-1:0];
      root_ext = GAIN_WIDTH'(ds_root);
      num = {1'b0, ref_energy_ff} + RATIO_WIDTH'(1);
      den = {1'b0, proc_energy_ff} + RATIO_WIDTH'(1);
   end

   always_comb begin
      energy_coef_in    = energy_coef_ff;
      activity_coef_in  = activity_coef_ff;
      gain_up_coef_in   = gain_up_coef_ff;
      gain_down_coef_in = gain_down_coef_ff;
      boot_coef_in      = boot_coef_ff;
      boot_length_in    = boot_length_ff;
      gate_energy_in    = gate_energy_ff;
      ref_energy_in     = ref_energy_ff;
      proc_energy_in    = proc_energy_ff;
      act_in            = act_ff;
      gain_in           = gain_ff;
      boot_left_in      = boot_left_ff;
      state_in          = state_ff;
      op_in             = op_ff;
      req_in            = req_ff;
      sq_in             = sq_ff;
      ref_inst_in       = ref_inst_ff;
      proc_inst_in      = proc_inst_ff;
      active_in         = active_ff;
      target_in         = target_ff;
      coef_in           = coef_ff;
      out_left_in       = out_left_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_data_in       = rsp_data_ff;
      mul_req           = '0;
      ds_req            = '0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ENERGY_COEF:    energy_coef_in    = csr_wdata[COEF_WIDTH-1:0];
            CSR_ACTIVITY_COEF:  activity_coef_in  = csr_wdata[COEF_WIDTH-1:0];
            CSR_GAIN_UP_COEF:   gain_up_coef_in   = csr_wdata[COEF_WIDTH-1:0];
            CSR_GAIN_DOWN_COEF: gain_down_coef_in = csr_wdata[COEF_WIDTH-1:0];
            CSR_BOOT_COEF:      boot_coef_in      = csr_wdata[COEF_WIDTH-1:0];
            CSR_BOOT_LENGTH:    boot_length_in    = csr_wdata[BOOT_WIDTH-1:0];
            CSR_GATE_ENERGY:    gate_energy_in    = csr_wdata[ENERGY_WIDTH-1:0];
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               op_in    = OP_SQ_RL;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            mul_req.start = 1'b1;
            state_in      = S_WAIT;
            case (op_ff)
               OP_SQ_RL: begin
                  mul_req.mcand  = MUL_M_WIDTH'(mag(req_ff.ref_left));
                  mul_req.mplier = MUL_N_WIDTH'(mag(req_ff.ref_left));
               end
               OP_SQ_RR: begin
                  mul_req.mcand  = MUL_M_WIDTH'(mag(req_ff.ref_right));
                  mul_req.mplier = MUL_N_WIDTH'(mag(req_ff.ref_right));
               end
               OP_SQ_PL: begin
                  mul_req.mcand  = MUL_M_WIDTH'(mag(req_ff.proc_left));
                  mul_req.mplier = MUL_N_WIDTH'(mag(req_ff.proc_left));
               end
               OP_SQ_PR: begin
                  mul_req.mcand  = MUL_M_WIDTH'(mag(req_ff.proc_right));
                  mul_req.mplier = MUL_N_WIDTH'(mag(req_ff.proc_right));
               end
               OP_BL_REF, OP_BL_PROC: begin
                  mul_req.mcand  = MUL_M_WIDTH'(signed'(bl_diff));
                  mul_req.mplier = energy_coef_ff;
               end
               OP_BL_ACT: begin
                  mul_req.mcand  = MUL_M_WIDTH'(signed'(bl_diff));
                  mul_req.mplier = activity_coef_ff;
               end
               OP_BL_GAIN: begin
                  mul_req.mcand  = MUL_M_WIDTH'(signed'(bl_diff));
                  mul_req.mplier = coef_ff;
               end
               OP_SC_LEFT: begin
                  mul_req.mcand  = MUL_M_WIDTH'(req_ff.proc_left);
                  mul_req.mplier = gain_ff;
               end
               default: begin
                  mul_req.mcand  = MUL_M_WIDTH'(req_ff.proc_right);
                  mul_req.mplier = gain_ff;
               end
            endcase
         end
         S_WAIT: begin
            if (mul_done) begin
               state_in = S_ISSUE;
               case (op_ff)
                  OP_SQ_RL: begin
                     sq_in = sq_now;
                     op_in = OP_SQ_RR;
                  end
                  OP_SQ_RR: begin
                     ref_inst_in = energy_of(sq_ff + sq_now);
                     op_in       = OP_SQ_PL;
                  end
                  OP_SQ_PL: begin
                     sq_in = sq_now;
                     op_in = OP_SQ_PR;
                  end
                  OP_SQ_PR: begin
                     proc_inst_in = energy_of(sq_ff + sq_now);
                     op_in        = OP_BL_REF;
                  end
                  OP_BL_REF: begin
                     ref_energy_in = bl_val;
                     op_in         = OP_BL_PROC;
                  end
                  OP_BL_PROC: begin
                     proc_energy_in = bl_val;
                     op_in          = OP_BL_ACT;
                  end
                  OP_BL_ACT: begin
                     // Peak hold: the new reference energy wins over the release.
                     act_in   = (ref_inst_ff > bl_val) ? ref_inst_ff : bl_val;
                     state_in = S_GATE;
                  end
                  OP_BL_GAIN: begin
                     gain_in = snapped;
                     op_in   = OP_SC_LEFT;
                  end
                  OP_SC_LEFT: begin
                     out_left_in = saturate(signed'(scaled[PROD_WIDTH-1:30]));
                     op_in       = OP_SC_RIGHT;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_GATE: begin
            active_in = act_ff > gate_energy_ff;
            state_in  = S_COEF;
            if (act_ff > gate_energy_ff) begin
               if ({2'b00, num} >= {den, 2'b00}) begin
                  target_in = MAX_G;
               end else if ({num, 2'b00} < {2'b00, den}) begin
                  target_in = MIN_G;
               end else begin
                  ds_req.start = 1'b1;
                  ds_req.num   = num;
                  ds_req.den   = den;
                  state_in     = S_ROOT;
               end
            end else begin
               ref_energy_in  = '0;
               proc_energy_in = '0;
               boot_left_in   = boot_length_ff;
               target_in      = UNITY_GAIN;
            end
         end
         S_ROOT: begin
            if (ds_done) begin
               if (root_ext < MIN_G) begin
                  target_in = MIN_G;
               end else if (root_ext > MAX_G) begin
                  target_in = MAX_G;
               end else begin
                  target_in = root_ext;
               end
               state_in = S_COEF;
            end
         end
         S_COEF: begin
            if (active_ff && boot_left_ff != '0) begin
               boot_left_in = boot_left_ff - BOOT_WIDTH'(1);
               coef_in      = boot_coef_ff;
            end else begin
               coef_in = (target_ff > gain_ff) ? gain_up_coef_ff : gain_down_coef_ff;
            end
            op_in    = OP_BL_GAIN;
            state_in = S_ISSUE;
         end
         S_OUT: begin
            // The right product stays in the idle multiplier until the output slot frees.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.out_right = saturate(signed'(scaled[PROD_WIDTH-1:30]));
               rsp_data_in.out_left  = out_left_ff;
               rsp_data_in.gain_now  = gain_ff[GAIN_OUT_WIDTH-1:0];
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_coef_ff    <= RST_ENERGY_COEF;
         activity_coef_ff  <= RST_ACTIVITY_COEF;
         gain_up_coef_ff   <= RST_GAIN_UP_COEF;
         gain_down_coef_ff <= RST_GAIN_DOWN_COEF;
         boot_coef_ff      <= RST_BOOT_COEF;
         boot_length_ff    <= RST_BOOT_LENGTH;
         gate_energy_ff    <= RST_GATE_ENERGY;
         ref_energy_ff     <= '0;
         proc_energy_ff    <= '0;
         act_ff            <= '0;
         gain_ff           <= UNITY_GAIN;
         boot_left_ff      <= RST_BOOT_LENGTH;
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         energy_coef_ff    <= energy_coef_in;
         activity_coef_ff  <= activity_coef_in;
         gain_up_coef_ff   <= gain_up_coef_in;
         gain_down_coef_ff <= gain_down_coef_in;
         boot_coef_ff      <= boot_coef_in;
         boot_length_ff    <= boot_length_in;
         gate_energy_ff    <= gate_energy_in;
         ref_energy_ff     <= ref_energy_in;
         proc_energy_ff    <= proc_energy_in;
         act_ff            <= act_in;
         gain_ff           <= gain_in;
         boot_left_ff      <= boot_left_in;
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      op_ff        <= op_in;
      req_ff       <= req_in;
      sq_ff        <= sq_in;
      ref_inst_ff  <= ref_inst_in;
      proc_inst_ff <= proc_inst_in;
      active_ff    <= active_in;
      target_ff    <= target_in;
      coef_ff      <= coef_in;
      out_left_ff  <= out_left_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ALM_ASSERT_IMPLIES(a_gain_range, clock, reset, 1'b1,
      (gain_ff >= MIN_G) && (gain_ff <= MAX_G), "smoothed gain left the clamp range")
   `ALM_ASSERT_IMPLIES(a_gated_clear, clock, reset, (state_ff == S_COEF) && !active_ff,
      (ref_energy_ff == '0) && (proc_energy_ff == '0), "gated request kept its energies")

endmodule

`default_nettype wire

// ----- dv/alm_checker.sv -----
// Checker for the level match gain core: predicts each result from the accepted requests
// and the register writes, and compares it with the response channel. Depends on alm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alm_checker import alm_pkg::*; #(
   parameter longint MIN_GAIN = 760151010,
   parameter longint MAX_GAIN = 1516700552
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire req_type                    req_data,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire rsp_type                    rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   logic [31:0] energy_coef, activity_coef, gain_up_coef, gain_down_coef, boot_coef;
   logic [16:0] boot_length, boot_left;
   logic [47:0] gate_energy, ref_energy, proc_energy, activity_energy;
   logic [31:0] gain;
   rsp_type     expected_q[$];

   // floor((c*a + (2^32 - c)*b) / 2^32) at full precision.
   function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [31:0] c);
      logic [127:0] s;
      s = 128'(a) * 128'(c) + 128'(b) * (128'h1_0000_0000 - 128'(c));
      return s[95:32];
   endfunction

   function automatic logic [47:0] pair_energy(longint a, longint b);
      longint ma, mb;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      return 48'((ma * ma + mb * mb) >> 1);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [31:0] gain_target(logic [47:0] re, logic [47:0] pe);
      logic [63:0]  n, d, g;
      logic [127:0] q;
      n = 64'(re) + 1;
      d = 64'(pe) + 1;
      if (n >= 4 * d) return 32'(MAX_GAIN);
      if (4 * n < d) return 32'(MIN_GAIN);
      q = (128'(n) << 60) / 128'(d);
      g = int_sqrt(q[63:0]);
      if (g < MIN_GAIN) g = MIN_GAIN;
      if (g > MAX_GAIN) g = MAX_GAIN;
      return g[31:0];
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] apply_gain(longint s, logic [31:0] g);
      longint p, y, hi;
      hi = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
      p = s * longint'({32'd0, g});
      y = (p + 64'sd536870912) >>> 30;
      if (y > hi) y = hi;
      if (y < -hi - 1) y = -hi - 1;
      return y[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic rsp_type level_match(req_type r);
      logic [47:0] ref_now, proc_now, released;
      logic [31:0] target, coef;
      logic        active, boot;
      rsp_type     o;
      ref_now = pair_energy(longint'(r.ref_left), longint'(r.ref_right));
      proc_now = pair_energy(longint'(r.proc_left), longint'(r.proc_right));
      ref_energy = 48'(blend(64'(ref_energy), 64'(ref_now), energy_coef));
      proc_energy = 48'(blend(64'(proc_energy), 64'(proc_now), energy_coef));
      released = 48'(blend(64'(activity_energy), '0, activity_coef));
      activity_energy = (ref_now > released) ? ref_now : released;
      active = activity_energy > gate_energy;
      target = UNITY_GAIN;
      if (active) begin
         target = gain_target(ref_energy, proc_energy);
      end else begin
         ref_energy = '0;
         proc_energy = '0;
         boot_left = boot_length;
      end
      boot = active && boot_left > 0;
      if (boot) begin
         boot_left = boot_left - 17'(1);
         coef = boot_coef;
      end else begin
         coef = (target > gain) ? gain_up_coef : gain_down_coef;
      end
      gain = 32'(blend(64'(gain), 64'(target), coef));
      if (64'(gain) + 1 >= 64'(UNITY_GAIN) && 64'(gain) <= 64'(UNITY_GAIN) + 1)
         gain = UNITY_GAIN;
      o.out_left = apply_gain(longint'(r.proc_left), gain);
      o.out_right = apply_gain(longint'(r.proc_right), gain);
      o.gain_now = gain[GAIN_OUT_WIDTH-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         energy_coef = RST_ENERGY_COEF;
         activity_coef = RST_ACTIVITY_COEF;
         gain_up_coef = RST_GAIN_UP_COEF;
         gain_down_coef = RST_GAIN_DOWN_COEF;
         boot_coef = RST_BOOT_COEF;
         boot_length = RST_BOOT_LENGTH;
         boot_left = RST_BOOT_LENGTH;
         gate_energy = RST_GATE_ENERGY;
         ref_energy = '0;
         proc_energy = '0;
         activity_energy = '0;
         gain = UNITY_GAIN;
         expected_q.delete();
         fail_count = 0;
         pending <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENERGY_COEF:    energy_coef = csr_wdata[31:0];
               CSR_ACTIVITY_COEF:  activity_coef = csr_wdata[31:0];
               CSR_GAIN_UP_COEF:   gain_up_coef = csr_wdata[31:0];
               CSR_GAIN_DOWN_COEF: gain_down_coef = csr_wdata[31:0];
               CSR_BOOT_COEF:      boot_coef = csr_wdata[31:0];
               CSR_BOOT_LENGTH:    boot_length = csr_wdata[16:0];
               CSR_GATE_ENERGY:    gate_energy = csr_wdata[47:0];
               default: ;
            endcase
         end
         // The response leaving at this edge always belongs to an earlier request.
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with nothing expected, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (want.out_left !== rsp_data.out_left) begin
                  $display("%0t: out_left expected %0d actual %0d", $time,
                           want.out_left, rsp_data.out_left);
                  fail_count++;
               end
               if (want.out_right !== rsp_data.out_right) begin
                  $display("%0t: out_right expected %0d actual %0d", $time,
                           want.out_right, rsp_data.out_right);
                  fail_count++;
               end
               if (want.gain_now !== rsp_data.gain_now) begin
                  $display("%0t: gain_now expected %0d actual %0d", $time,
                           want.gain_now, rsp_data.gain_now);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) expected_q.push_back(level_match(req_data));
         pending <= expected_q.size();
      end
   end

endmodule

`default_nettype wire

// ----- dv/tb_auto_level_match_gain_core.sv -----
// Testbench top for the level match gain core: drives requests, responder stalls and
// register writes, and gives the verdict. Depends on alm_pkg, alm_checker and the core.
`timescale 1ns / 1ps
`default_nettype none

module tb_auto_level_match_gain_core;
   import alm_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   int                         fail_count, pending;
   int                         cycle_count = 0;
   int                         scene = 0, scene_left = 0, proc_shift = 0;

   localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   auto_level_match_gain_core u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_wr_en, .csr_index, .csr_wdata
   );

   alm_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_wr_en, .csr_index, .csr_wdata, .fail_count, .pending
   );

   // The first fifth of every repeating window of cycles has no receiver stalls.
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_ready <= (cycle_count % 20000 < 4000) || ($urandom_range(99) >= 20);
   end

   // Valid stays up after the accepting edge until the next request or a pause replaces it.
   task automatic send_frame(input req_type r, input bit calm);
      if (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(int kind);
      case (kind)
         0: return '0;
         1: return SAMPLE_WIDTH'($signed($urandom_range(511)) - 256);
         2: return $urandom_range(1) ? SMAX : SMIN;
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   // Programme runs as scenes: silence, music-like passages where the processed pair
   // tracks the reference at some level offset, and unrelated noise.
   function automatic req_type next_frame();
      req_type r;
      if (scene_left == 0) begin
         scene = $urandom_range(9);
         scene_left = $urandom_range(10, 80);
         proc_shift = $urandom_range(3);
      end
      scene_left--;
      if (scene < 2) begin
         r.ref_left = pick_sample($urandom_range(1));
         r.ref_right = pick_sample($urandom_range(1));
         r.proc_left = pick_sample($urandom_range(1));
         r.proc_right = pick_sample($urandom_range(1));
      end else if (scene < 8) begin
         r.ref_left = pick_sample($urandom_range(9) == 0 ? 2 : 3);
         r.ref_right = pick_sample(3);
         r.proc_left = (r.ref_left >>> proc_shift) ^ SAMPLE_WIDTH'($urandom_range(255));
         r.proc_right = (scene == 7) ? r.ref_right <<< 1 : r.ref_right >>> proc_shift;
      end else begin
         r.ref_left = pick_sample($urandom_range(3));
         r.ref_right = pick_sample($urandom_range(3));
         r.proc_left = pick_sample($urandom_range(3));
         r.proc_right = pick_sample($urandom_range(3));
      end
      return r;
   endfunction

   task automatic run_frames(input int count);
      for (int i = 0; i < count; i++) send_frame(next_frame(), i < 60);
   endtask

   task automatic write_all(input logic [47:0] c0, input logic [47:0] c1,
                            input logic [47:0] c2, input logic [47:0] c3,
                            input logic [47:0] c4, input logic [47:0] blen,
                            input logic [47:0] gate);
      write_reg(CSR_ENERGY_COEF, c0);
      write_reg(CSR_ACTIVITY_COEF, c1);
      write_reg(CSR_GAIN_UP_COEF, c2);
      write_reg(CSR_GAIN_DOWN_COEF, c3);
      write_reg(CSR_BOOT_COEF, c4);
      write_reg(CSR_BOOT_LENGTH, blen);
      write_reg(CSR_GATE_ENERGY, gate);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed frames at reset settings: field extremes, silence, clamping both ways.
      send_frame('{SMAX, SMAX, SMAX, SMAX}, 1);
      send_frame('{SMIN, SMIN, SMIN, SMIN}, 1);
      send_frame('{SMAX, SMIN, '0, '0}, 1);
      send_frame('{'0, '0, SMAX, SMIN}, 1);
      send_frame('{'0, '0, '0, '0}, 1);
      for (int i = 0; i < 8; i++) send_frame('{SMAX, SMIN, 24'sd1, -24'sd1}, 1);
      for (int i = 0; i < 6; i++) send_frame('{24'sd1000, -24'sd1000, SMAX, SMIN}, 1);
      send_frame('{SMIN, SMAX, SMIN, SMAX}, 1);
      send_frame('{24'sd1, -24'sd1, 24'sd0, -24'sd1}, 1);
      run_frames(180);
      // Sender holds off here until every expected result is back.
      wait_idle();

      // All coefficients zero: no smoothing at all, no bootstrap, gate fully open.
      write_all(48'hFFFF_0000_0000, 0, 0, 0, 0, 0, 0);
      run_frames(180);
      wait_idle();

      // All registers at their top value; the gate can never open.
      write_all('1, '1, '1, '1, '1, '1, '1);
      run_frames(100);
      wait_idle();

      // Short bootstrap with moderate poles; the index past the last register is a no-op.
      write_all({16'hABCD, 32'hF000_0000}, 32'hE000_0000, 32'hC000_0000,
                32'hD000_0000, 32'h8000_0000, 3, 48'h100_0000_0000);
      write_reg(3'd7, '1);
      run_frames(260);
      wait_idle();

      write_all(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), 32'h8000_0000,
                32'h4000_0000, 48'({$urandom, $urandom}),
                48'({$urandom, $urandom} | 64'h10), 48'($urandom_range(1 << 20)));
      run_frames(260);
      wait_idle();

      write_all(RST_ENERGY_COEF, 32'hFF00_0000, RST_GAIN_UP_COEF, RST_GAIN_DOWN_COEF,
                RST_BOOT_COEF, 40, RST_GATE_ENERGY);
      run_frames(300);
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
